// ===== hw/rtl/mcdc_pkg.sv =====
package mcdc_pkg;

    localparam int unsigned MAX_DUTY_DEF = 250;
    localparam int unsigned PCT_FULL     = 100;
    localparam int unsigned VOLT_W       = 18;
    localparam int unsigned POWER_W      = 24;
    localparam int unsigned CURR_W       = 16;
    localparam int unsigned PCT_W        = 7;
    localparam int unsigned DUTY_W       = 8;
    localparam int unsigned DUTY_EXT_W   = DUTY_W + 2;
    localparam int unsigned PCT_N        = 2 ** PCT_W;
    localparam int unsigned CFG_DATA_W   = 18;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned MPPT_MIN_CURR = 100;

    typedef logic [VOLT_W-1:0]            volt_t;
    typedef logic [POWER_W-1:0]           power_t;
    typedef logic signed [CURR_W-1:0]     curr_t;
    typedef logic [CURR_W-1:0]            limit_t;
    typedef logic [PCT_W-1:0]             pct_t;
    typedef logic [DUTY_W-1:0]            duty_t;
    typedef logic [DUTY_EXT_W-1:0]        duty_ext_t;
    typedef logic [CFG_DATA_W-1:0]        cfg_data_t;
    typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_MPPT   = 2'd1,
        MODE_CCCV   = 2'd2,
        MODE_PID    = 2'd3
    } mode_t;

    localparam cfg_idx_t REG_MODE           = 2'd0;
    localparam cfg_idx_t REG_CURRENT_LIMIT  = 2'd1;
    localparam cfg_idx_t REG_VOLTAGE_TARGET = 2'd2;
    localparam cfg_idx_t REG_DROPOUT_MARGIN = 2'd3;

    typedef struct packed {
        mode_t  mode;
        limit_t current_limit;
        volt_t  voltage_target;
        limit_t dropout_margin;
    } cfg_t;

    typedef struct packed {
        volt_t  in_voltage;
        power_t in_power;
        volt_t  out_voltage;
        curr_t  out_current;
        pct_t   manual_percent;
    } meas_t;

    typedef struct packed {
        duty_t  duty;
        power_t prev_power;
        volt_t  prev_voltage;
    } state_t;

endpackage

// ===== hw/rtl/mcdc_meas_if.sv =====
interface mcdc_meas_if import mcdc_pkg::*; ();
    logic   valid;
    logic   ready;
    volt_t  in_voltage;
    power_t in_power;
    volt_t  out_voltage;
    curr_t  out_current;
    pct_t   manual_percent;

    modport source (
        output valid,
        output in_voltage,
        output in_power,
        output out_voltage,
        output out_current,
        output manual_percent,
        input  ready
    );

    modport sink (
        input  valid,
        input  in_voltage,
        input  in_power,
        input  out_voltage,
        input  out_current,
        input  manual_percent,
        output ready
    );
endinterface

// ===== hw/rtl/mcdc_duty_if.sv =====
interface mcdc_duty_if import mcdc_pkg::*; ();
    logic  valid;
    logic  ready;
    duty_t duty;

    modport source (
        output valid,
        output duty,
        input  ready
    );

    modport sink (
        input  valid,
        input  duty,
        output ready
    );
endinterface

// ===== hw/rtl/mcdc_law.sv =====
module mcdc_law import mcdc_pkg::*; #(
    parameter int unsigned MAX_DUTY = MAX_DUTY_DEF
) (
    input  cfg_t   cfg,
    input  meas_t  meas,
    input  state_t state_cur,
    output state_t state_new
);

    localparam duty_ext_t DutyTop = DUTY_EXT_W'(MAX_DUTY);

    // manual duty table: percent scaled to full duty, clamped at the top
    duty_t man_lut [PCT_N];

    for (genvar i = 0; i < PCT_N; i++)
    begin : g_lut
        localparam int unsigned Q = (i * MAX_DUTY) / PCT_FULL;
        assign man_lut[i] = DUTY_W'((Q > MAX_DUTY) ? MAX_DUTY : Q);
    end

    logic        over_i;
    logic        cur_ok;
    logic        no_cur;
    logic        v_hi;
    logic        v_lo;
    logic        headroom;
    logic        pu;
    logic        pd;
    logic        vu;
    logic        vd;
    logic [VOLT_W:0] need;
    duty_ext_t   d_keep;
    duty_ext_t   d_dec;
    duty_ext_t   d_inc;
    duty_ext_t   d;

    // negative current is never over the limit
    assign over_i   = !meas.out_current[CURR_W-1]
                      && ({1'b0, meas.out_current[CURR_W-2:0]} > cfg.current_limit);
    assign cur_ok   = !meas.out_current[CURR_W-1]
                      && (meas.out_current[CURR_W-2:0] > (CURR_W-1)'(MPPT_MIN_CURR));
    assign no_cur   = meas.out_current[CURR_W-1] || (meas.out_current == '0);
    assign v_hi     = meas.out_voltage > cfg.voltage_target;
    assign v_lo     = meas.out_voltage < cfg.voltage_target;
    assign need     = {1'b0, meas.out_voltage} + (VOLT_W+1)'(cfg.dropout_margin)
                      + (VOLT_W+1)'(1);
    assign headroom = {1'b0, meas.in_voltage} >= need;
    assign pu       = meas.in_power > state_cur.prev_power;
    assign pd       = meas.in_power < state_cur.prev_power;
    assign vu       = meas.in_voltage > state_cur.prev_voltage;
    assign vd       = meas.in_voltage < state_cur.prev_voltage;

    assign d_keep = DUTY_EXT_W'(state_cur.duty);
    assign d_dec  = (state_cur.duty != '0) ? d_keep - DUTY_EXT_W'(1) : '0;
    assign d_inc  = d_keep + DUTY_EXT_W'(1);

    always_comb
    begin
        state_new = state_cur;
        d         = d_keep;
        case (cfg.mode)
            MODE_MANUAL:
            begin
                if (over_i)
                    d = d_dec;
                else
                    d = DUTY_EXT_W'(man_lut[meas.manual_percent]);
            end
            MODE_CCCV:
            begin
                if (over_i || v_hi)
                    d = d_dec;
                else if (v_lo)
                    d = d_inc;
                state_new.prev_voltage = meas.in_voltage;
            end
            MODE_MPPT:
            begin
                if (over_i || v_hi)
                begin
                    d = d_dec;
                end
                else
                begin
                    if (cur_ok && headroom)
                    begin
                        // perturb and observe
                        if (pu && vu)
                            d = d_dec;
                        else if ((pu && vd) || (pd && vu))
                            d = d_inc;
                        else if (pd && vd)
                            d = d_dec;
                        else if (v_hi)
                            d = d_dec;
                        else if (v_lo)
                            d = d_inc;
                    end
                    else
                    begin
                        d = d_dec;
                    end
                    // kick when no output current flows
                    if (no_cur)
                        d = d + DUTY_EXT_W'(2);
                    state_new.prev_power   = meas.in_power;
                    state_new.prev_voltage = meas.in_voltage;
                end
            end
            default:
            begin
                d = d_keep;
            end
        endcase
        state_new.duty = (d > DutyTop) ? DUTY_W'(MAX_DUTY) : d[DUTY_W-1:0];
    end

endmodule

// ===== hw/rtl/mppt_cccv_duty_controller_core.sv =====
// a duty beat is presented in the cycle after its measurement beat is taken
// throughput: one measurement beat per cycle while the duty output is taken, set by the single duty update stage
// input ready stays high while the output register is empty or being drained
// reset: asynchronous active-low rst_n clears the registers, duty and stored
// power and voltage to zero and drops the output valid
module mppt_cccv_duty_controller_core import mcdc_pkg::*; #(
    parameter int unsigned MAX_DUTY = MAX_DUTY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  cfg_idx_t    cfg_index,
    input  cfg_data_t   cfg_data,
    mcdc_meas_if.sink   meas,
    mcdc_duty_if.source pwm
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    state_t state_reg;
    state_t state_next;
    state_t state_calc;
    logic   valid_reg;
    logic   valid_next;
    logic   accept;
    meas_t  meas_beat;

    assign meas.ready = !valid_reg || pwm.ready;
    assign accept     = meas.valid && meas.ready;

    assign meas_beat.in_voltage     = meas.in_voltage;
    assign meas_beat.in_power       = meas.in_power;
    assign meas_beat.out_voltage    = meas.out_voltage;
    assign meas_beat.out_current    = meas.out_current;
    assign meas_beat.manual_percent = meas.manual_percent;

    mcdc_law #(
        .MAX_DUTY (MAX_DUTY)
    ) u_law (
        .cfg       (cfg_reg),
        .meas      (meas_beat),
        .state_cur (state_reg),
        .state_new (state_calc)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:           cfg_next.mode           = mode_t'(cfg_data[1:0]);
                REG_CURRENT_LIMIT:  cfg_next.current_limit  = cfg_data[CURR_W-1:0];
                REG_VOLTAGE_TARGET: cfg_next.voltage_target = cfg_data[VOLT_W-1:0];
                REG_DROPOUT_MARGIN: cfg_next.dropout_margin = cfg_data[CURR_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = accept ? state_calc : state_reg;
        if (accept)
            valid_next = 1'b1;
        else if (pwm.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            state_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign pwm.valid = valid_reg;
    assign pwm.duty  = state_reg.duty;

`ifndef SYNTHESIS
    a_duty_top: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.duty <= DUTY_W'(MAX_DUTY))
        else $error("duty above maximum");

    a_pid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cfg_reg.mode == MODE_PID) |=> $stable(state_reg))
        else $error("duty or stored values moved in held mode");

    a_cccv_power: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cfg_reg.mode == MODE_CCCV) |=> $stable(state_reg.prev_power))
        else $error("stored power changed in supply mode");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg))
        else $error("state changed without an input beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !meas.ready |-> (valid_reg && !pwm.ready))
        else $error("input stalled with a free output register");
`endif

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import mcdc_pkg::*;

    localparam int DUTY_TOP    = MAX_DUTY_DEF;
    localparam int PCT_TOP     = PCT_FULL;
    localparam int MIN_I       = MPPT_MIN_CURR;
    localparam int VOLT_MAX    = 2 ** VOLT_W - 1;
    localparam int POWER_MAX   = 2 ** POWER_W - 1;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 100;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic      is_cfg;
        cfg_idx_t  idx;
        cfg_data_t data;
        meas_t     m;
        logic      has_exp;
        duty_t     exp_duty;
    } plan_row_t;

    typedef struct {
        bit    has;
        duty_t val;
    } fixed_duty_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    mcdc_meas_if meas_ch ();
    mcdc_duty_if duty_ch ();

    mppt_cccv_duty_controller_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas      (meas_ch),
        .pwm       (duty_ch)
    );

    // predictor copy of registers and state
    mode_t  cf_mode     = MODE_MANUAL;
    limit_t cf_climit   = '0;
    volt_t  cf_vtarget  = '0;
    limit_t cf_margin   = '0;
    duty_t  st_duty     = '0;
    power_t st_prev_pwr = '0;
    volt_t  st_prev_v   = '0;

    duty_t       duty_q[$];
    fixed_duty_t fixed_q[$];
    plan_row_t   plan[$];

    int beats_in     = 0;
    int beats_out    = 0;
    int err_count    = 0;
    int idle_cycles  = 0;
    int g_vin        = 0;
    int g_pin        = 0;
    bit hold_off_req = 0;
    bit quiet        = 0;

    mode_t phase_mode[6] = '{MODE_MPPT, MODE_MANUAL, MODE_MPPT, MODE_CCCV, MODE_MPPT, MODE_PID};

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int dec_floor(input int v);
        return (v > 0) ? v - 1 : 0;
    endfunction

    function automatic duty_t next_duty(input meas_t m);
        int d;
        int vout;
        int cur;
        int need;
        bit over_i;
        bit pu;
        bit pd;
        bit vu;
        bit vd;
        d      = int'(st_duty);
        vout   = int'(m.out_voltage);
        cur    = int'($signed(m.out_current));
        over_i = cur > int'(cf_climit);
        case (cf_mode)
            MODE_MANUAL:
            begin
                if (over_i)
                    d = dec_floor(d);
                else
                begin
                    d = (int'(m.manual_percent) * DUTY_TOP) / PCT_TOP;
                    if (d > DUTY_TOP)
                        d = DUTY_TOP;
                end
            end
            MODE_CCCV:
            begin
                if (over_i)
                    d = dec_floor(d);
                else if (vout > int'(cf_vtarget))
                    d = dec_floor(d);
                else if (vout < int'(cf_vtarget))
                    d = d + 1;
                if (d > DUTY_TOP)
                    d = DUTY_TOP;
                st_prev_v = m.in_voltage;
            end
            MODE_MPPT:
            begin
                if (over_i)
                    d = dec_floor(d);
                else if (vout > int'(cf_vtarget))
                    d = dec_floor(d);
                else
                begin
                    need = vout + int'(cf_margin) + 1;
                    if (cur > MIN_I && int'(m.in_voltage) >= need)
                    begin
                        pu = m.in_power > st_prev_pwr;
                        pd = m.in_power < st_prev_pwr;
                        vu = m.in_voltage > st_prev_v;
                        vd = m.in_voltage < st_prev_v;
                        if (pu && vu)
                            d = dec_floor(d);
                        else if (pu && vd)
                            d = d + 1;
                        else if (pd && vu)
                            d = d + 1;
                        else if (pd && vd)
                            d = dec_floor(d);
                        else if (vout > int'(cf_vtarget))
                            d = dec_floor(d);
                        else if (vout < int'(cf_vtarget))
                            d = d + 1;
                    end
                    else
                        d = dec_floor(d);
                    // no output current: kick after the decrement
                    if (cur <= 0)
                        d = d + 2;
                    st_prev_pwr = m.in_power;
                    st_prev_v   = m.in_voltage;
                end
                if (d > DUTY_TOP)
                    d = DUTY_TOP;
            end
            default:
            begin
            end
        endcase
        st_duty = duty_t'(d);
        return st_duty;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_value(input int lo_val, input int hi_val,
                                      input int rnd_lo, input int rnd_hi);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return lo_val;
        else if (r == 1)
            return hi_val;
        return $urandom_range(rnd_lo, rnd_hi);
    endfunction

    // mostly well-formed tracking samples around a drifting operating point
    function automatic meas_t make_item();
        meas_t m;
        int    lim_v;
        int    lim_i;
        int    cur;
        if ($urandom_range(0, 9) < 2)
        begin
            m.in_voltage     = volt_t'($urandom);
            m.in_power       = power_t'($urandom);
            m.out_voltage    = volt_t'($urandom);
            m.out_current    = curr_t'($urandom);
            m.manual_percent = pct_t'($urandom);
            return m;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            g_vin = $urandom_range(0, VOLT_MAX);
            g_pin = $urandom_range(0, POWER_MAX);
        end
        g_vin = g_vin + int'($urandom_range(0, 4)) - 2;
        g_pin = g_pin + int'($urandom_range(0, 4)) - 2;
        if (g_vin < 0)
            g_vin = 0;
        if (g_vin > VOLT_MAX)
            g_vin = VOLT_MAX;
        if (g_pin < 0)
            g_pin = 0;
        if (g_pin > POWER_MAX)
            g_pin = POWER_MAX;
        m.in_voltage = volt_t'(g_vin);
        m.in_power   = power_t'(g_pin);
        lim_v = g_vin - int'(cf_margin) - 1;
        if (lim_v > int'(cf_vtarget))
            lim_v = int'(cf_vtarget);
        if (lim_v >= 0 && $urandom_range(0, 7) != 0)
            m.out_voltage = volt_t'($urandom_range(0, lim_v));
        else
            m.out_voltage = volt_t'($urandom_range(0, VOLT_MAX));
        lim_i = (cf_climit > 32767) ? 32767 : int'(cf_climit);
        case ($urandom_range(0, 7))
            0:       cur = -int'($urandom_range(0, 32768));
            1:       cur = $urandom_range(0, 32767);
            default: cur = (lim_i >= 101) ? int'($urandom_range(101, lim_i))
                                          : int'($urandom_range(0, 32767));
        endcase
        m.out_current = curr_t'(cur);
        if ($urandom_range(0, 9) == 0)
            m.manual_percent = pct_t'($urandom_range(101, 127));
        else
            m.manual_percent = pct_t'($urandom_range(0, 100));
        return m;
    endfunction

    function automatic plan_row_t cfg_row(input cfg_idx_t i, input cfg_data_t v);
        plan_row_t row;
        row.is_cfg   = 1'b1;
        row.idx      = i;
        row.data     = v;
        row.m        = '0;
        row.has_exp  = 1'b0;
        row.exp_duty = '0;
        return row;
    endfunction

    function automatic plan_row_t meas_row(input int vin, input int pin, input int vout,
                                           input int cur, input int pct,
                                           input bit has, input int e);
        plan_row_t row;
        row.is_cfg           = 1'b0;
        row.idx              = REG_MODE;
        row.data             = '0;
        row.m.in_voltage     = volt_t'(vin);
        row.m.in_power       = power_t'(pin);
        row.m.out_voltage    = volt_t'(vout);
        row.m.out_current    = curr_t'(cur);
        row.m.manual_percent = pct_t'(pct);
        row.has_exp          = has;
        row.exp_duty         = duty_t'(e);
        return row;
    endfunction

    task automatic send_meas(input meas_t m);
        meas_ch.valid          <= 1'b1;
        meas_ch.in_voltage     <= m.in_voltage;
        meas_ch.in_power       <= m.in_power;
        meas_ch.out_voltage    <= m.out_voltage;
        meas_ch.out_current    <= m.out_current;
        meas_ch.manual_percent <= m.manual_percent;
        do
            @(posedge clk);
        while (meas_ch.ready !== 1'b1);
        beats_in++;
    endtask

    task automatic drain();
        while (beats_out != beats_in)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t i, input cfg_data_t v);
        cfg_we    <= 1'b1;
        cfg_index <= i;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic gap_after(input bit burst);
        int g;
        g = burst ? 0 : pick_gap();
        if (g > 0)
        begin
            meas_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // predictor update and duty check on every beat
    always @(posedge clk)
    begin : scoreboard
        meas_t       m;
        duty_t       d;
        duty_t       e;
        fixed_duty_t fx;
        if (rst_n === 1'b1)
        begin
            if (cfg_we === 1'b1)
            begin
                case (cfg_index)
                    REG_MODE:           cf_mode    = mode_t'(cfg_data[1:0]);
                    REG_CURRENT_LIMIT:  cf_climit  = cfg_data[15:0];
                    REG_VOLTAGE_TARGET: cf_vtarget = cfg_data;
                    REG_DROPOUT_MARGIN: cf_margin  = cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (meas_ch.valid === 1'b1 && meas_ch.ready === 1'b1)
            begin
                m.in_voltage     = meas_ch.in_voltage;
                m.in_power       = meas_ch.in_power;
                m.out_voltage    = meas_ch.out_voltage;
                m.out_current    = meas_ch.out_current;
                m.manual_percent = meas_ch.manual_percent;
                d  = next_duty(m);
                fx = fixed_q.pop_front();
                duty_q.push_back(fx.has ? fx.val : d);
            end
            if (duty_ch.valid === 1'b1 && duty_ch.ready === 1'b1)
            begin
                if (duty_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected duty beat, expected none, got %0d",
                             $time, duty_ch.duty);
                end
                else
                begin
                    e = duty_q.pop_front();
                    if (duty_ch.duty !== e)
                    begin
                        err_count++;
                        $display("%0t: duty mismatch, expected %0d, got %0d",
                                 $time, e, duty_ch.duty);
                    end
                end
                beats_out++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || cfg_we === 1'b1
            || (meas_ch.valid === 1'b1 && meas_ch.ready === 1'b1)
            || (duty_ch.valid === 1'b1 && duty_ch.ready === 1'b1))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin : rx_side
        int run;
        int g;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 0;
                duty_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            duty_ch.ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            g = quiet ? 0 : pick_gap();
            if (g > 0)
            begin
                duty_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    initial
    begin : tx_side
        plan_row_t   row;
        fixed_duty_t fx;
        meas_t       m;
        cfg_data_t   v;
        bit          burst;

        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= REG_MODE;
        cfg_data               <= '0;
        meas_ch.valid          <= 1'b0;
        meas_ch.in_voltage     <= '0;
        meas_ch.in_power       <= '0;
        meas_ch.out_voltage    <= '0;
        meas_ch.out_current    <= '0;
        meas_ch.manual_percent <= '0;
        duty_ch.ready          <= 1'b0;

        // manual mode from reset
        plan.push_back(meas_row(0, 0, 0, 0, 0, 1, 0));
        plan.push_back(meas_row(VOLT_MAX, POWER_MAX, VOLT_MAX, -32768, 100, 1, 250));
        plan.push_back(meas_row(0, 0, 0, 0, 127, 1, 250));
        plan.push_back(meas_row(0, 0, 0, 1, 50, 1, 249));
        plan.push_back(cfg_row(REG_CURRENT_LIMIT, 18'h3FFFF));
        plan.push_back(meas_row(0, 0, 0, 32767, 40, 1, 100));
        plan.push_back(cfg_row(REG_CURRENT_LIMIT, 18'h00000));
        plan.push_back(meas_row(0, 0, 0, 0, 0, 1, 0));
        plan.push_back(meas_row(0, 0, 0, 5, 77, 1, 0));
        plan.push_back(meas_row(0, 0, 0, 0, 100, 1, 250));
        // cc-cv, step up against the top
        plan.push_back(cfg_row(REG_MODE, 18'h3FFFE));
        plan.push_back(cfg_row(REG_VOLTAGE_TARGET, 18'h3FFFF));
        plan.push_back(meas_row(5, 0, 0, 0, 0, 1, 250));
        plan.push_back(meas_row(5, 0, VOLT_MAX, 0, 0, 1, 250));
        plan.push_back(cfg_row(REG_CURRENT_LIMIT, 18'd1000));
        plan.push_back(meas_row(7, 0, 0, 1001, 0, 1, 249));
        plan.push_back(meas_row(9, 0, 0, -32768, 0, 0, 0));
        plan.push_back(cfg_row(REG_VOLTAGE_TARGET, 18'd0));
        plan.push_back(meas_row(11, 0, 1, 0, 0, 0, 0));
        // perturb and observe
        plan.push_back(cfg_row(REG_MODE, 18'd1));
        plan.push_back(cfg_row(REG_VOLTAGE_TARGET, 18'd200000));
        plan.push_back(cfg_row(REG_DROPOUT_MARGIN, 18'd1000));
        plan.push_back(cfg_row(REG_CURRENT_LIMIT, 18'd5000));
        plan.push_back(meas_row(10000, 50000, 5000, 500, 10, 0, 0));
        plan.push_back(meas_row(9990, 60000, 5000, 500, 10, 0, 0));
        plan.push_back(meas_row(10010, 40000, 5000, 500, 10, 0, 0));
        plan.push_back(meas_row(10000, 30000, 5000, 500, 10, 0, 0));
        plan.push_back(meas_row(10000, 30000, 5000, 500, 10, 0, 0));
        plan.push_back(meas_row(10000, 30000, 9000, 500, 10, 0, 0));
        plan.push_back(meas_row(100, 30000, 5000, 0, 10, 0, 0));
        plan.push_back(meas_row(12000, 20000, 250000, 500, 10, 0, 0));
        plan.push_back(meas_row(12000, 20000, 5000, 6000, 10, 0, 0));
        plan.push_back(cfg_row(REG_DROPOUT_MARGIN, 18'h3FFFF));
        plan.push_back(meas_row(VOLT_MAX, POWER_MAX, 0, 101, 10, 0, 0));
        // duty held
        plan.push_back(cfg_row(REG_MODE, 18'd3));
        plan.push_back(meas_row(1234, 5678, 0, -1, 100, 0, 0));
        plan.push_back(meas_row(0, 0, VOLT_MAX, 32767, 0, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_cfg)
            begin
                meas_ch.valid <= 1'b0;
                drain();
                write_reg(row.idx, row.data);
                cfg_we <= 1'b0;
            end
            else
            begin
                fx.has = row.has_exp;
                fx.val = row.exp_duty;
                fixed_q.push_back(fx);
                send_meas(row.m);
                gap_after(1'b0);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            meas_ch.valid <= 1'b0;
            drain();
            v = cfg_data_t'($urandom);
            v[1:0] = phase_mode[p % 6];
            write_reg(REG_MODE, v);
            v = cfg_data_t'($urandom);
            v[15:0] = limit_t'(pick_value(0, 65535, 200, 30000));
            write_reg(REG_CURRENT_LIMIT, v);
            write_reg(REG_VOLTAGE_TARGET,
                      cfg_data_t'(pick_value(0, VOLT_MAX, 1000, 250000)));
            v = cfg_data_t'($urandom);
            v[15:0] = limit_t'(pick_value(0, 65535, 0, 3000));
            write_reg(REG_DROPOUT_MARGIN, v);
            cfg_we <= 1'b0;

            // output held off while input keeps coming
            if (p == 4)
                hold_off_req = 1;
            quiet = (p == 9);
            burst = (p == 4) || (p == 9);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 6 && k == 50)
                begin
                    meas_ch.valid <= 1'b0;
                    drain();
                end
                fx.has = 0;
                fx.val = '0;
                fixed_q.push_back(fx);
                m = make_item();
                send_meas(m);
                gap_after(burst);
            end
        end

        meas_ch.valid <= 1'b0;
        drain();
        if (err_count == 0 && duty_q.size() == 0)
            $display("tb: success");
        else
        begin
            if (duty_q.size() != 0)
                $display("%0t: %0d duty beats never arrived", $time, duty_q.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
